// ----- rtl/core/afrd_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// afrd_pkg
// Shared types and constants of the frame receive deframer.
// ----------------------------------------------------------------------------
package afrd_pkg;

  localparam logic [7:0]  START_BYTE   = 8'h7E;
  localparam logic [7:0]  SUM_GOOD     = 8'hFF;
  localparam logic [15:0] MAX_LEN_RST  = 16'd255;

  localparam logic [2:0] PH_HUNT    = 3'd0;
  localparam logic [2:0] PH_LEN_HI  = 3'd1;
  localparam logic [2:0] PH_LEN_LO  = 3'd2;
  localparam logic [2:0] PH_PAYLOAD = 3'd3;
  localparam logic [2:0] PH_CHECK   = 3'd4;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_CHECKSUM  = 2'd1;
  localparam logic [1:0] ST_SIZE      = 2'd2;
  localparam logic [1:0] ST_INTEGRITY = 2'd3;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       line_error;
  } item_t;

  typedef struct packed {
    logic [7:0]  payload_byte;
    logic        is_payload;
    logic        frame_end;
    logic [1:0]  status;
    logic [15:0] frame_length;
  } res_t;

endpackage

// ----- rtl/core/api_frame_receive_deframer.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// api_frame_receive_deframer
// Receive deframer for start byte, length and checksum serial frames.
// ----------------------------------------------------------------------------
// The block takes one byte per cycle while the result side does not stall. Each
// result passes two registers, the input register and then the result register,
// with the frame state updated in between. Stalls on the result side hold both
// registers. Payload bytes come out as they arrive; the frame end
// result carries the status and the length. A line error on any byte reports
// an integrity error and restarts the hunt for the start byte. The maximum
// payload length register resets to 255 and should be written while idle.
module api_frame_receive_deframer
  import afrd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_rx_byte,
  input  logic        in_line_error,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_payload_byte,
  output logic        out_is_payload,
  output logic        out_frame_end,
  output logic [1:0]  out_status,
  output logic [15:0] out_frame_length,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_max_payload_length
);

  logic [15:0] max_len_r;
  logic        out_free;
  logic        item_valid;
  logic        item_fire;
  item_t       item;
  logic        res_valid;
  res_t        res;

  assign cfg_ready = 1'b1;
  assign item_fire = item_valid && out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_len_r <= MAX_LEN_RST;
    end else if (cfg_valid && cfg_ready) begin
      max_len_r <= cfg_max_payload_length;
    end
  end

  afrd_in_stage u_in (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_rx_byte    (in_rx_byte),
    .in_line_error (in_line_error),
    .advance       (out_free),
    .item_valid    (item_valid),
    .item          (item)
  );

  afrd_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .item_fire (item_fire),
    .item      (item),
    .max_len   (max_len_r),
    .res_valid (res_valid),
    .res       (res)
  );

  afrd_out_stage u_out (
    .clk              (clk),
    .rst_n            (rst_n),
    .res_valid        (res_valid),
    .res              (res),
    .out_free         (out_free),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_payload_byte (out_payload_byte),
    .out_is_payload   (out_is_payload),
    .out_frame_end    (out_frame_end),
    .out_status       (out_status),
    .out_frame_length (out_frame_length)
  );

endmodule

// ----- rtl/core/afrd_in_stage.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// afrd_in_stage
// Input register that holds one received byte until the parser takes it.
// ----------------------------------------------------------------------------
module afrd_in_stage
  import afrd_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_rx_byte,
  input  logic       in_line_error,
  input  logic       advance,
  output logic       item_valid,
  output item_t      item
);

  logic  valid_r;
  logic  valid_nxt;
  item_t item_r;

  assign in_stall   = valid_r && !advance;
  assign valid_nxt  = in_valid || (valid_r && !advance);
  assign item_valid = valid_r;
  assign item       = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      item_r.rx_byte    <= in_rx_byte;
      item_r.line_error <= in_line_error;
    end
  end

endmodule

// ----- rtl/core/afrd_parser.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// afrd_parser
// Frame state machine: start byte hunt, length, payload and checksum check.
// ----------------------------------------------------------------------------
module afrd_parser
  import afrd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        item_fire,
  input  item_t       item,
  input  logic [15:0] max_len,
  output logic        res_valid,
  output res_t        res
);

  logic [2:0]  phase_r;
  logic [2:0]  phase_nxt;
  logic [15:0] plen_r;
  logic [15:0] plen_nxt;
  logic [15:0] count_r;
  logic [15:0] count_nxt;
  logic [7:0]  sum_r;
  logic [7:0]  sum_nxt;
  logic [15:0] len_full;
  logic [15:0] count_inc;
  logic [7:0]  sum_add;
  logic        emit;

  assign len_full  = {plen_r[15:8], item.rx_byte};
  assign count_inc = count_r + 16'd1;
  assign sum_add   = sum_r + item.rx_byte;

  always_comb begin
    phase_nxt = phase_r;
    plen_nxt  = plen_r;
    count_nxt = count_r;
    sum_nxt   = sum_r;
    emit      = 1'b0;
    res       = '0;
    if (item.line_error) begin
      phase_nxt  = PH_HUNT;
      count_nxt  = '0;
      sum_nxt    = '0;
      emit       = 1'b1;
      res.frame_end = 1'b1;
      res.status    = ST_INTEGRITY;
    end else begin
      case (phase_r)
        PH_HUNT: begin
          if (item.rx_byte == START_BYTE) begin
            phase_nxt = PH_LEN_HI;
          end
        end
        PH_LEN_HI: begin
          plen_nxt  = {item.rx_byte, 8'h00};
          phase_nxt = PH_LEN_LO;
        end
        PH_LEN_LO: begin
          plen_nxt  = len_full;
          count_nxt = '0;
          sum_nxt   = '0;
          if (len_full > max_len) begin
            phase_nxt        = PH_HUNT;
            emit             = 1'b1;
            res.frame_end    = 1'b1;
            res.status       = ST_SIZE;
            res.frame_length = len_full;
          end else if (len_full == 16'd0) begin
            phase_nxt = PH_CHECK;
          end else begin
            phase_nxt = PH_PAYLOAD;
          end
        end
        PH_PAYLOAD: begin
          sum_nxt   = sum_add;
          count_nxt = count_inc;
          if (count_inc >= plen_r) begin
            phase_nxt = PH_CHECK;
          end
          emit             = 1'b1;
          res.payload_byte = item.rx_byte;
          res.is_payload   = 1'b1;
        end
        PH_CHECK: begin
          phase_nxt        = PH_HUNT;
          count_nxt        = '0;
          sum_nxt          = '0;
          emit             = 1'b1;
          res.frame_end    = 1'b1;
          res.status       = (sum_add == SUM_GOOD) ? ST_OK : ST_CHECKSUM;
          res.frame_length = plen_r;
        end
        default: begin
          phase_nxt = PH_HUNT;
          count_nxt = '0;
          sum_nxt   = '0;
        end
      endcase
    end
  end

  assign res_valid = item_fire && emit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HUNT;
      plen_r  <= '0;
      count_r <= '0;
      sum_r   <= '0;
    end else if (item_fire) begin
      phase_r <= phase_nxt;
      plen_r  <= plen_nxt;
      count_r <= count_nxt;
      sum_r   <= sum_nxt;
    end
  end

  a_payload_clean: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid && res.is_payload |-> !res.frame_end && res.status == ST_OK)
    else $error("payload result carries frame end or error status");

  a_payload_phase: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid && res.is_payload |-> phase_r == PH_PAYLOAD)
    else $error("payload result outside payload phase");

  a_end_to_hunt: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid && res.frame_end |=> phase_r == PH_HUNT && sum_r == 8'd0)
    else $error("frame end did not return to hunting");

  a_line_error: assert property (@(posedge clk) disable iff (!rst_n)
    item_fire && item.line_error |-> res_valid && res.status == ST_INTEGRITY)
    else $error("line error did not report integrity error");

endmodule

// ----- rtl/core/afrd_out_stage.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// afrd_out_stage
// Result register that holds one result until the consumer takes it.
// ----------------------------------------------------------------------------
module afrd_out_stage
  import afrd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        res_valid,
  input  res_t        res,
  output logic        out_free,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_payload_byte,
  output logic        out_is_payload,
  output logic        out_frame_end,
  output logic [1:0]  out_status,
  output logic [15:0] out_frame_length
);

  logic valid_r;
  res_t res_r;

  assign out_free         = !valid_r || !out_stall;
  assign out_valid        = valid_r;
  assign out_payload_byte = res_r.payload_byte;
  assign out_is_payload   = res_r.is_payload;
  assign out_frame_end    = res_r.frame_end;
  assign out_status       = res_r.status;
  assign out_frame_length = res_r.frame_length;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (out_free) begin
      valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && res_valid) begin
      res_r <= res;
    end
  end

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking regression of the frame receive deframer. A short table of
// directed bytes covers empty frames, size, checksum and integrity errors and
// the start byte as data, and then random frames run under several maximum
// lengths and idling patterns. Every result is checked against the table's
// expected result or an in-bench model of the deframer's frame state.
// ----------------------------------------------------------------------------
module tb;
  import afrd_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int SEGMENT_ITEMS = 160;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_rx_byte = 8'h00;
  logic        in_line_error = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  out_payload_byte;
  logic        out_is_payload;
  logic        out_frame_end;
  logic [1:0]  out_status;
  logic [15:0] out_frame_length;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [15:0] cfg_max_payload_length = 16'd0;

  // Model state of the deframer.
  logic [2:0]  phase;
  logic [15:0] frame_len;
  logic [15:0] byte_cnt;
  logic [7:0]  run_sum;
  logic [15:0] max_len;

  typedef struct {
    item_t      in;
    logic       typed;
    res_t       want;
  } row_t;

  res_t        pending_results[$];
  row_t        directed_rows[$];
  int          mismatches = 0;
  int          consumed_items = 0;
  int          tx_idle_pct = 0;
  int          rx_stall_pct = 0;
  int unsigned cycles = 0;

  api_frame_receive_deframer i_dut (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .in_valid               (in_valid),
    .in_stall               (in_stall),
    .in_rx_byte             (in_rx_byte),
    .in_line_error          (in_line_error),
    .out_valid              (out_valid),
    .out_stall              (out_stall),
    .out_payload_byte       (out_payload_byte),
    .out_is_payload         (out_is_payload),
    .out_frame_end          (out_frame_end),
    .out_status             (out_status),
    .out_frame_length       (out_frame_length),
    .cfg_valid              (cfg_valid),
    .cfg_ready              (cfg_ready),
    .cfg_max_payload_length (cfg_max_payload_length)
  );

  always #10 clk = ~clk;

  function automatic item_t mk_item(input logic [7:0] b, input logic e);
    item_t it;
    it.rx_byte = b;
    it.line_error = e;
    return it;
  endfunction

  function automatic res_t frame_result(input logic [1:0] st, input logic [15:0] len);
    res_t r;
    r.payload_byte = 8'h00;
    r.is_payload = 1'b0;
    r.frame_end = 1'b1;
    r.status = st;
    r.frame_length = len;
    return r;
  endfunction

  function automatic void restart_hunt();
    phase = PH_HUNT;
    byte_cnt = 16'd0;
    run_sum = 8'd0;
  endfunction

  // Advances the frame state by one byte. Returns 0 for a byte dropped while
  // hunting, 1 for any byte that the deframer acts on.
  function automatic logic deframe_step(input item_t it, output logic has_res,
                                        output res_t r);
    has_res = 1'b0;
    r = '0;
    if (it.line_error) begin
      restart_hunt();
      has_res = 1'b1;
      r = frame_result(ST_INTEGRITY, 16'd0);
      return 1'b1;
    end
    case (phase)
      PH_HUNT: begin
        if (it.rx_byte == START_BYTE) begin
          phase = PH_LEN_HI;
          return 1'b1;
        end
        return 1'b0;
      end
      PH_LEN_HI: begin
        frame_len = {it.rx_byte, 8'h00};
        phase = PH_LEN_LO;
      end
      PH_LEN_LO: begin
        frame_len = {frame_len[15:8], it.rx_byte};
        byte_cnt = 16'd0;
        run_sum = 8'd0;
        if (frame_len > max_len) begin
          restart_hunt();
          has_res = 1'b1;
          r = frame_result(ST_SIZE, frame_len);
        end else begin
          phase = (frame_len == 16'd0) ? PH_CHECK : PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        run_sum = run_sum + it.rx_byte;
        byte_cnt = byte_cnt + 16'd1;
        if (byte_cnt >= frame_len) phase = PH_CHECK;
        has_res = 1'b1;
        r.payload_byte = it.rx_byte;
        r.is_payload = 1'b1;
      end
      PH_CHECK: begin
        has_res = 1'b1;
        r = frame_result((8'(run_sum + it.rx_byte) == SUM_GOOD) ? ST_OK : ST_CHECKSUM,
                         frame_len);
        restart_hunt();
      end
      default: restart_hunt();
    endcase
    return 1'b1;
  endfunction

  function automatic void check_field(input string name, input logic [15:0] want,
                                      input logic [15:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      mismatches++;
    end
  endfunction

  // Called right after a rising edge; returns at the edge of the transfer.
  task automatic send_item(input item_t it, input logic typed, input res_t want);
    logic has_res;
    res_t r;
    if ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_rx_byte <= it.rx_byte;
    in_line_error <= it.line_error;
    do @(posedge clk); while (in_stall !== 1'b0);
    if (deframe_step(it, has_res, r)) consumed_items++;
    if (typed) pending_results.push_back(want);
    else if (has_res) pending_results.push_back(r);
  endtask

  task automatic send_frame();
    item_t       seq[$];
    int unsigned pick;
    int unsigned len;
    int          cut;
    logic [7:0]  b;
    logic [7:0]  sum;
    logic [7:0]  ck;
    if ($urandom_range(99) < 8) begin
      repeat ($urandom_range(1, 4))
        seq.push_back(mk_item(8'($urandom), $urandom_range(15) == 0));
    end else begin
      pick = $urandom_range(99);
      if (pick < 60) len = $urandom_range(0, 6);
      else if (pick < 88) len = $urandom_range(7, 40);
      else if (pick < 92 && max_len <= 16'd257) len = max_len + $urandom_range(0, 1);
      else begin
        len = $urandom_range(0, 65535);
        if (len <= max_len && len > 64) len = len % 64;
      end
      seq.push_back(mk_item(START_BYTE, 1'b0));
      seq.push_back(mk_item(8'(len >> 8), 1'b0));
      seq.push_back(mk_item(8'(len), 1'b0));
      if (len <= max_len) begin
        sum = 8'd0;
        for (int i = 0; i < len; i++) begin
          b = 8'($urandom);
          sum = sum + b;
          seq.push_back(mk_item(b, 1'b0));
        end
        ck = SUM_GOOD - sum;
        if ($urandom_range(99) < 15) ck = ck ^ 8'($urandom_range(1, 255));
        seq.push_back(mk_item(ck, 1'b0));
      end
      if ($urandom_range(99) < 6) begin
        cut = $urandom_range(0, seq.size() - 1);
        seq[cut].line_error = 1'b1;
        seq = seq[0:cut];
      end
    end
    foreach (seq[i]) send_item(seq[i], 1'b0, '0);
  endtask

  task automatic settle_block();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
  endtask

  task automatic write_max_len(input logic [15:0] v);
    cfg_valid <= 1'b1;
    cfg_max_payload_length <= v;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    max_len = v;
    cfg_valid <= 1'b0;
  endtask

  task automatic add_row(input logic [7:0] b, input logic e, input logic typed,
                         input logic [1:0] st, input logic [15:0] len);
    row_t row;
    row.in = mk_item(b, e);
    row.typed = typed;
    row.want = frame_result(st, len);
    directed_rows.push_back(row);
  endtask

  always @(posedge clk) begin
    if (!rst_n) out_stall <= 1'b0;
    else out_stall <= ($urandom_range(99) < rx_stall_pct);
  end

  always @(posedge clk) begin
    res_t want;
    if (rst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %0h %0b %0b %0d %0h",
                 $time, out_payload_byte, out_is_payload, out_frame_end, out_status,
                 out_frame_length);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        check_field("payload_byte", 16'(want.payload_byte), 16'(out_payload_byte));
        check_field("is_payload", 16'(want.is_payload), 16'(out_is_payload));
        check_field("frame_end", 16'(want.frame_end), 16'(out_frame_end));
        check_field("status", 16'(want.status), 16'(out_status));
        check_field("frame_length", want.frame_length, out_frame_length);
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("api_frame_receive_deframer regression: fail");
      $finish;
    end
  end

  initial begin
    logic [15:0] seg_max[6];
    int          start_cnt;
    max_len = MAX_LEN_RST;
    frame_len = 16'd0;
    restart_hunt();
    seg_max[0] = 16'd255;
    seg_max[1] = 16'd0;
    seg_max[2] = 16'd65535;
    seg_max[3] = 16'($urandom_range(1, 64));
    seg_max[4] = 16'd257;
    seg_max[5] = 16'd8;

    add_row(8'h00, 1'b1, 1'b1, ST_INTEGRITY, 16'd0);
    add_row(8'h55, 1'b0, 1'b0, ST_OK, 16'd0);
    add_row(8'h7E, 1'b0, 1'b0, ST_OK, 16'd0);
    add_row(8'h00, 1'b0, 1'b0, ST_OK, 16'd0);
    add_row(8'h00, 1'b0, 1'b0, ST_OK, 16'd0);
    add_row(8'hFF, 1'b0, 1'b1, ST_OK, 16'd0);
    add_row(8'h7E, 1'b0, 1'b0, ST_OK, 16'd0);
    add_row(8'h01, 1'b0, 1'b0, ST_OK, 16'd0);
    add_row(8'h00, 1'b0, 1'b1, ST_SIZE, 16'd256);
    add_row(8'h7E, 1'b0, 1'b0, ST_OK, 16'd0);
    add_row(8'h00, 1'b0, 1'b0, ST_OK, 16'd0);
    add_row(8'h02, 1'b0, 1'b0, ST_OK, 16'd0);
    add_row(8'h7E, 1'b0, 1'b0, ST_OK, 16'd0);
    add_row(8'hFF, 1'b0, 1'b0, ST_OK, 16'd0);
    add_row(8'h82, 1'b0, 1'b1, ST_OK, 16'd2);
    add_row(8'h7E, 1'b0, 1'b0, ST_OK, 16'd0);
    add_row(8'h00, 1'b0, 1'b0, ST_OK, 16'd0);
    add_row(8'h01, 1'b0, 1'b0, ST_OK, 16'd0);
    add_row(8'h00, 1'b0, 1'b0, ST_OK, 16'd0);
    add_row(8'h00, 1'b0, 1'b1, ST_CHECKSUM, 16'd1);
    add_row(8'h7E, 1'b0, 1'b0, ST_OK, 16'd0);
    add_row(8'h00, 1'b0, 1'b0, ST_OK, 16'd0);
    add_row(8'hAA, 1'b1, 1'b1, ST_INTEGRITY, 16'd0);
    add_row(8'h7E, 1'b0, 1'b0, ST_OK, 16'd0);
    add_row(8'h00, 1'b0, 1'b0, ST_OK, 16'd0);
    add_row(8'h05, 1'b0, 1'b0, ST_OK, 16'd0);
    add_row(8'h11, 1'b0, 1'b0, ST_OK, 16'd0);
    add_row(8'h22, 1'b1, 1'b1, ST_INTEGRITY, 16'd0);

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    tx_idle_pct = 15;
    rx_stall_pct = 65;
    foreach (directed_rows[i])
      send_item(directed_rows[i].in, directed_rows[i].typed, directed_rows[i].want);

    for (int s = 0; s < 6; s++) begin
      if (s == 2) begin
        tx_idle_pct = 65;
        rx_stall_pct = 15;
      end else if (s == 4) begin
        tx_idle_pct = 0;
        rx_stall_pct = 0;
      end
      settle_block();
      write_max_len(seg_max[s]);
      start_cnt = consumed_items;
      while (consumed_items - start_cnt < SEGMENT_ITEMS) send_frame();
    end

    settle_block();
    if (mismatches == 0 && pending_results.size() == 0)
      $display("api_frame_receive_deframer regression: pass");
    else
      $display("api_frame_receive_deframer regression: fail");
    $finish;
  end

endmodule
